>>> src/range_wrap_up_down_counter_defines.svh
// Assertion macros used by the counter's datapath.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RANGE_WRAP_UP_DOWN_COUNTER_DEFINES_SVH
`define RANGE_WRAP_UP_DOWN_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWUDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWUDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rwudc_pkg.sv
package rwudc_pkg;

    // Width of the count, the range limits and the steps.
    localparam int COUNT_WIDTH = 32;
    // An exact count plus increment minus decrement needs two extra bits.
    localparam int SUM_WIDTH = COUNT_WIDTH + 2;
    // The range size reaches 2**COUNT_WIDTH, so it needs one extra bit.
    localparam int SIZE_WIDTH = COUNT_WIDTH + 1;
    // Width of the divider step counter; one dividend bit is taken per step.
    localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);

    localparam int REG_COUNT = 6;
    localparam int ADDR_WIDTH = $clog2(REG_COUNT * 4);
    localparam int REG_IDX_WIDTH = ADDR_WIDTH - 2;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_RANGE_MINIMUM  = 3'd0,
        REG_RANGE_MAXIMUM  = 3'd1,
        REG_WRAP_MODE      = 3'd2,
        REG_INCREMENT_STEP = 3'd3,
        REG_DECREMENT_STEP = 3'd4,
        REG_INITIAL_COUNT  = 3'd5
    } reg_idx_t;

    // Values of the wrap_mode register.
    localparam logic MODE_WRAP     = 1'b0;
    localparam logic MODE_SATURATE = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] RANGE_MINIMUM_RESET  = COUNT_WIDTH'(0);
    localparam logic [COUNT_WIDTH-1:0] RANGE_MAXIMUM_RESET  = COUNT_WIDTH'(10);
    localparam logic                   WRAP_MODE_RESET      = MODE_WRAP;
    localparam logic [COUNT_WIDTH-1:0] INCREMENT_STEP_RESET = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] DECREMENT_STEP_RESET = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] INITIAL_COUNT_RESET  = COUNT_WIDTH'(0);

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] range_minimum;
        logic [COUNT_WIDTH-1:0] range_maximum;
        logic                   wrap_mode;
        logic [COUNT_WIDTH-1:0] increment_step;
        logic [COUNT_WIDTH-1:0] decrement_step;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_SUM,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic clamp;
        logic sum;
        logic prep;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic inverted;
        logic need_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/rwudc_event_if.sv
interface rwudc_event_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      do_increment;
    logic                                      do_decrement;
    logic                                      do_set;
    logic signed [rwudc_pkg::COUNT_WIDTH-1:0]  set_value;

    modport source (
        output valid,
        output do_increment,
        output do_decrement,
        output do_set,
        output set_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  do_increment,
        input  do_decrement,
        input  do_set,
        input  set_value,
        output ready
    );
endinterface

>>> src/rwudc_result_if.sv
interface rwudc_result_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [rwudc_pkg::COUNT_WIDTH-1:0]  count_out;
    logic                                      range_error;

    modport source (
        output valid,
        output count_out,
        output range_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  count_out,
        input  range_error,
        output ready
    );
endinterface

>>> src/range_wrap_up_down_counter.sv
// Channel  | Role        | Payload
// ---------+-------------+-----------------------------------------------
// event    | sink        | do_increment, do_decrement, do_set, set_value
// result   | source      | count_out, range_error
// config   | APB slave   | six registers at byte addresses 0, 4, ... 20
//
// A wrapping event goes through the clamp, sum and prep states, 34 steps of
// the radix-2 remainder unit and a commit; then the idle state takes the next
// event. Without a wrap the remainder steps are skipped; an inverted range
// goes from clamp straight to commit. rst_n (asynchronous) restores the
// register defaults and the count. A waiting result lets the next event run
// and stalls it at its commit only while that result is still not taken.

module range_wrap_up_down_counter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rwudc_event_if.sink                          event_ch,
    rwudc_result_if.source                       result_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rwudc_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [rwudc_pkg::COUNT_WIDTH-1:0]    pwdata,
    output logic [rwudc_pkg::COUNT_WIDTH-1:0]    prdata,
    output logic                                 pready
);

    // Register file contents that the datapath uses.
    rwudc_pkg::cfg_t       cfg;
    // Commands from the sequencer and status back from the datapath.
    rwudc_pkg::ctrl_cmd_t  cmd;
    rwudc_pkg::dp_status_t status;

    // The configuration registers sit behind a plain APB slave with no wait
    // states; writes are expected only while no event is in flight.
    rwudc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sequencer walks each event through clamp, sum, limit check, the
    // optional remainder loop and the commit of the new count.
    rwudc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (event_ch.valid),
        .status   (status),
        .cmd      (cmd)
    );

    assign event_ch.ready = cmd.in_ready;

    // The datapath holds the count, the event operands, the remainder unit
    // and the output register.
    rwudc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .do_increment (event_ch.do_increment),
        .do_decrement (event_ch.do_decrement),
        .do_set       (event_ch.do_set),
        .set_value    (event_ch.set_value),
        .out_ready    (result_ch.ready),
        .out_valid    (result_ch.valid),
        .count_out    (result_ch.count_out),
        .range_error  (result_ch.range_error)
    );

endmodule

>>> src/rwudc_cfg.sv
module rwudc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rwudc_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [rwudc_pkg::COUNT_WIDTH-1:0]    pwdata,
    output logic [rwudc_pkg::COUNT_WIDTH-1:0]    prdata,
    output logic                                 pready,
    output rwudc_pkg::cfg_t                      cfg
);

    logic [rwudc_pkg::COUNT_WIDTH-1:0]   min_reg;
    logic [rwudc_pkg::COUNT_WIDTH-1:0]   max_reg;
    logic                                wrap_reg;
    logic [rwudc_pkg::COUNT_WIDTH-1:0]   inc_reg;
    logic [rwudc_pkg::COUNT_WIDTH-1:0]   dec_reg;
    logic [rwudc_pkg::COUNT_WIDTH-1:0]   init_reg;
    logic [rwudc_pkg::REG_IDX_WIDTH-1:0] idx;
    logic                                wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[rwudc_pkg::ADDR_WIDTH-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= rwudc_pkg::RANGE_MINIMUM_RESET;
            max_reg  <= rwudc_pkg::RANGE_MAXIMUM_RESET;
            wrap_reg <= rwudc_pkg::WRAP_MODE_RESET;
            inc_reg  <= rwudc_pkg::INCREMENT_STEP_RESET;
            dec_reg  <= rwudc_pkg::DECREMENT_STEP_RESET;
            init_reg <= rwudc_pkg::INITIAL_COUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                rwudc_pkg::REG_RANGE_MINIMUM:  min_reg  <= pwdata;
                rwudc_pkg::REG_RANGE_MAXIMUM:  max_reg  <= pwdata;
                rwudc_pkg::REG_WRAP_MODE:      wrap_reg <= pwdata[0];
                rwudc_pkg::REG_INCREMENT_STEP: inc_reg  <= pwdata;
                rwudc_pkg::REG_DECREMENT_STEP: dec_reg  <= pwdata;
                rwudc_pkg::REG_INITIAL_COUNT:  init_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rwudc_pkg::REG_RANGE_MINIMUM:  prdata = min_reg;
            rwudc_pkg::REG_RANGE_MAXIMUM:  prdata = max_reg;
            rwudc_pkg::REG_WRAP_MODE:
                prdata = {{(rwudc_pkg::COUNT_WIDTH-1){1'b0}}, wrap_reg};
            rwudc_pkg::REG_INCREMENT_STEP: prdata = inc_reg;
            rwudc_pkg::REG_DECREMENT_STEP: prdata = dec_reg;
            rwudc_pkg::REG_INITIAL_COUNT:  prdata = init_reg;
            default:                       prdata = '0;
        endcase
    end

    assign cfg.range_minimum  = min_reg;
    assign cfg.range_maximum  = max_reg;
    assign cfg.wrap_mode      = wrap_reg;
    assign cfg.increment_step = inc_reg;
    assign cfg.decrement_step = dec_reg;

endmodule

>>> src/rwudc_ctrl.sv
module rwudc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  rwudc_pkg::dp_status_t   status,
    output rwudc_pkg::ctrl_cmd_t    cmd
);

    rwudc_pkg::state_t state_reg;
    rwudc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwudc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            rwudc_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rwudc_pkg::S_CLAMP;
                end
            end
            rwudc_pkg::S_CLAMP:
            begin
                // An inverted range skips the arithmetic entirely.
                cmd.clamp  = 1'b1;
                state_next = status.inverted ? rwudc_pkg::S_DONE : rwudc_pkg::S_SUM;
            end
            rwudc_pkg::S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = rwudc_pkg::S_PREP;
            end
            rwudc_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.need_div ? rwudc_pkg::S_DIV : rwudc_pkg::S_DONE;
            end
            rwudc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = rwudc_pkg::S_DONE;
                end
            end
            rwudc_pkg::S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = rwudc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rwudc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/rwudc_dp.sv
`include "range_wrap_up_down_counter_defines.svh"

module rwudc_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  rwudc_pkg::cfg_t                          cfg,
    input  rwudc_pkg::ctrl_cmd_t                     cmd,
    output rwudc_pkg::dp_status_t                    status,
    input  logic                                     do_increment,
    input  logic                                     do_decrement,
    input  logic                                     do_set,
    input  logic signed [rwudc_pkg::COUNT_WIDTH-1:0] set_value,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic signed [rwudc_pkg::COUNT_WIDTH-1:0] count_out,
    output logic                                     range_error
);

    localparam int CW = rwudc_pkg::COUNT_WIDTH;
    localparam int SW = rwudc_pkg::SUM_WIDTH;
    localparam int ZW = rwudc_pkg::SIZE_WIDTH;
    localparam logic [SW-1:0] ONE_SUM  = {{(SW-1){1'b0}}, 1'b1};
    localparam logic [ZW-1:0] ONE_SIZE = {{(ZW-1){1'b0}}, 1'b1};
    localparam logic [rwudc_pkg::DIV_CNT_WIDTH-1:0] DIV_LAST =
        rwudc_pkg::DIV_CNT_WIDTH'(SW - 1);
    localparam logic [rwudc_pkg::DIV_CNT_WIDTH-1:0] ONE_CNT =
        rwudc_pkg::DIV_CNT_WIDTH'(1);

    function automatic logic [SW-1:0] sext_sum(input logic [CW-1:0] v);
        return {{(SW-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic [SW-1:0] do_inc_term(input logic en, input logic [CW-1:0] v);
        return en ? sext_sum(v) : '0;
    endfunction

    logic [CW-1:0]                      count_reg;
    logic                               inc_reg;
    logic                               dec_reg;
    logic                               set_reg;
    logic [CW-1:0]                      set_value_reg;
    logic [CW-1:0]                      clamp_reg;
    logic                               inv_reg;
    logic [SW-1:0]                      sum_reg;
    logic                               above_reg;
    logic                               below_reg;
    logic [SW-1:0]                      dvd_reg;
    logic [SW-1:0]                      rem_reg;
    logic [ZW-1:0]                      size_reg;
    logic [rwudc_pkg::DIV_CNT_WIDTH-1:0] cnt_reg;
    logic                               out_valid_reg;
    logic [CW-1:0]                      out_count_reg;
    logic                               out_err_reg;

    logic          inverted;
    logic          above;
    logic          below;
    logic [SW-1:0] add_term;
    logic [SW-1:0] sub_term;
    logic [SW-1:0] sum_next;
    logic [SW-1:0] dvd_next;
    logic [ZW-1:0] size_next;
    logic [SW-1:0] trial;
    logic          trial_ge;
    logic [CW-1:0] result;

    assign inverted = $signed(cfg.range_maximum) < $signed(cfg.range_minimum);
    assign above    = $signed(sum_reg) > $signed(sext_sum(cfg.range_maximum));
    assign below    = $signed(sum_reg) < $signed(sext_sum(cfg.range_minimum));

    assign add_term = do_inc_term(inc_reg, cfg.increment_step);
    assign sub_term = do_inc_term(dec_reg, cfg.decrement_step);
    assign sum_next = set_reg ? sext_sum(set_value_reg)
                              : sext_sum(clamp_reg) + add_term - sub_term;

    // Distance past the violated limit, always non-negative when it is used.
    assign dvd_next = above ? (sum_reg - sext_sum(cfg.range_maximum) - ONE_SUM)
                            : (sext_sum(cfg.range_minimum) - ONE_SUM - sum_reg);
    assign size_next = {cfg.range_maximum[CW-1], cfg.range_maximum}
                     - {cfg.range_minimum[CW-1], cfg.range_minimum} + ONE_SIZE;

    // Restoring remainder step: one dividend bit per cycle.
    assign trial    = {rem_reg[SW-2:0], dvd_reg[SW-1]};
    assign trial_ge = trial >= {1'b0, size_reg};

    always_comb
    begin
        if (inv_reg)
        begin
            result = cfg.range_minimum;
        end
        else if (!above_reg && !below_reg)
        begin
            result = sum_reg[CW-1:0];
        end
        else if (cfg.wrap_mode == rwudc_pkg::MODE_SATURATE)
        begin
            result = above_reg ? cfg.range_maximum : cfg.range_minimum;
        end
        else if (above_reg)
        begin
            result = cfg.range_minimum + rem_reg[CW-1:0];
        end
        else
        begin
            result = cfg.range_maximum - rem_reg[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= rwudc_pkg::INITIAL_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            count_reg     <= result;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            inc_reg       <= do_increment;
            dec_reg       <= do_decrement;
            set_reg       <= do_set;
            set_value_reg <= set_value;
        end
        if (cmd.clamp)
        begin
            inv_reg <= inverted;
            if ($signed(count_reg) > $signed(cfg.range_maximum))
            begin
                clamp_reg <= cfg.range_maximum;
            end
            else if ($signed(count_reg) < $signed(cfg.range_minimum))
            begin
                clamp_reg <= cfg.range_minimum;
            end
            else
            begin
                clamp_reg <= count_reg;
            end
        end
        if (cmd.sum)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.prep)
        begin
            above_reg <= above;
            below_reg <= below;
            dvd_reg   <= dvd_next;
            size_reg  <= size_next;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? (trial - {1'b0, size_reg}) : trial;
            dvd_reg <= {dvd_reg[SW-2:0], 1'b0};
            cnt_reg <= cnt_reg + ONE_CNT;
        end
        if (cmd.commit)
        begin
            out_count_reg <= result;
            out_err_reg   <= inv_reg;
        end
    end

    assign status.inverted = inverted;
    assign status.need_div = (cfg.wrap_mode == rwudc_pkg::MODE_WRAP) && (above || below);
    assign status.div_last = cnt_reg == DIV_LAST;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign count_out   = out_count_reg;
    assign range_error = out_err_reg;

    `RWUDC_ASSERT_SAME(a_rem_below_size, cmd.div_step, rem_reg < {1'b0, size_reg},
        "divider remainder reached the range size")
    `RWUDC_ASSERT_SAME(a_commit_slot_free, cmd.commit, !out_valid_reg || out_ready,
        "result committed over an untaken result")
    `RWUDC_ASSERT_NEXT(a_inverted_holds_min, cmd.commit && inv_reg,
        out_err_reg && (count_reg == $past(cfg.range_minimum)),
        "inverted range did not hold the count at the minimum")

endmodule

>>> tb/range_wrap_up_down_counter_tb.sv
`timescale 1ns / 100ps

module range_wrap_up_down_counter_tb;

    import rwudc_pkg::*;

    // Time a wrapping event spends inside the block between transfers.
    localparam int EVENT_LATENCY = 39;
    // Watchdog limit for the whole run.
    localparam int LIMIT_CYCLES  = 1_000_000;
    // Chance, in percent, that a side holds off at each random draw.
    localparam int IDLE_PERCENT  = 33;

    localparam logic signed [COUNT_WIDTH-1:0] MOST_POS = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] MOST_NEG = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // One counting event as it is offered on the event channel.
    typedef struct packed {
        logic                          inc;
        logic                          dec;
        logic                          set;
        logic signed [COUNT_WIDTH-1:0] value;
    } count_event_t;

    // The count and error flag that one event must produce.
    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] count;
        logic                          err;
    } count_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_WIDTH-1:0]  paddr;
    logic [COUNT_WIDTH-1:0] pwdata;
    logic [COUNT_WIDTH-1:0] prdata;
    logic                   pready;

    rwudc_event_if  event_ch ();
    rwudc_result_if result_ch ();

    range_wrap_up_down_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (event_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Our own copy of the register file and the stored count. These are
    // updated at the same clock edge at which the block takes the write or
    // the event transfer, so the prediction always sees the block's view.
    logic signed [COUNT_WIDTH-1:0] model_min;
    logic signed [COUNT_WIDTH-1:0] model_max;
    logic                          model_mode;
    logic signed [COUNT_WIDTH-1:0] model_inc;
    logic signed [COUNT_WIDTH-1:0] model_dec;
    logic signed [COUNT_WIDTH-1:0] model_init;
    logic signed [COUNT_WIDTH-1:0] model_count;

    // Counts that have been predicted but not yet seen on the result channel,
    // oldest first.
    count_result_t pending_counts[$];

    int error_count;
    int cycle_count;
    // When set, neither side inserts idle cycles.
    bit no_idle;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog. A hung handshake or a lost result ends the run here.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("range_wrap_up_down_counter_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Predictor. The intermediate sum is kept exactly in 64 bits, which is
    // plenty for a 32-bit count plus two 32-bit steps. An inverted range
    // parks the count at the minimum and flags the error no matter what the
    // event asks for. Otherwise the stored count is first clamped into the
    // range, the steps or the set value are applied, and the sum is folded
    // back by a remainder on the range size or clamped, per the mode.
    function automatic count_result_t next_count(input count_event_t ev);
        count_result_t r;
        longint        lo;
        longint        hi;
        longint        acc;
        longint        span;
        lo = longint'($signed(model_min));
        hi = longint'($signed(model_max));
        if (hi < lo)
        begin
            model_count = model_min;
            r.count     = model_min;
            r.err       = 1'b1;
            return r;
        end
        acc = longint'($signed(model_count));
        if (acc > hi)
            acc = hi;
        if (acc < lo)
            acc = lo;
        if (ev.inc)
            acc += longint'($signed(model_inc));
        if (ev.dec)
            acc -= longint'($signed(model_dec));
        if (ev.set)
            acc = longint'($signed(ev.value));
        if (model_mode == MODE_SATURATE)
        begin
            if (acc > hi)
                acc = hi;
            if (acc < lo)
                acc = lo;
        end
        else
        begin
            // Distances past the limit are never negative, so the
            // remainder here has no sign issues even at a full-width range.
            span = hi - lo + 1;
            if (acc > hi)
                acc = lo + (acc - hi - 1) % span;
            else if (acc < lo)
                acc = hi - (lo - 1 - acc) % span;
        end
        model_count = COUNT_WIDTH'(acc);
        r.count     = model_count;
        r.err       = 1'b0;
        return r;
    endfunction

    function automatic count_event_t mk_event(input logic inc, input logic dec,
                                              input logic set,
                                              input logic signed [COUNT_WIDTH-1:0] value);
        count_event_t ev;
        ev.inc   = inc;
        ev.dec   = dec;
        ev.set   = set;
        ev.value = value;
        return ev;
    endfunction

    // Uniform value in [0, span), span up to a little over 2**32.
    function automatic longint rand_below(input longint span);
        return longint'({$urandom, $urandom} % 64'(span));
    endfunction

    // Steps lean toward the interesting corners: unit, small positive and
    // negative values, the two extremes, and full random words.
    function automatic logic [COUNT_WIDTH-1:0] pick_step();
        case ($urandom_range(5))
            0:       return COUNT_WIDTH'(1);
            1:       return COUNT_WIDTH'($urandom_range(20, 1));
            2:       return COUNT_WIDTH'(-longint'($urandom_range(20, 1)));
            3:       return $urandom;
            4:       return MOST_POS;
            default: return MOST_NEG;
        endcase
    endfunction

    // The event sender. Idle cycles go in front of the item at random, then
    // valid stays up until the block takes the transfer. Valid is left high
    // afterwards, so a back-to-back item never lowers and raises it within
    // one time step. The expectation is formed at the accepting edge.
    task automatic send_event(input count_event_t ev);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            event_ch.valid <= 1'b0;
            @(posedge clk);
        end
        event_ch.valid        <= 1'b1;
        event_ch.do_increment <= ev.inc;
        event_ch.do_decrement <= ev.dec;
        event_ch.do_set       <= ev.set;
        event_ch.set_value    <= ev.value;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        pending_counts.push_back(next_count(ev));
    endtask

    // Stop offering events and wait until every predicted count has come
    // back. At least one edge passes, so whatever follows is driven in a
    // later time step than the last transfer.
    task automatic drain_results();
        event_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_counts.size() != 0);
    endtask

    // One APB write: setup cycle, then access cycle until pready. psel is
    // left high so that a following write can go straight into its setup
    // cycle; configure() releases the bus after the last one.
    task automatic apb_write(input reg_idx_t idx, input logic [COUNT_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_RANGE_MINIMUM:  model_min  = value;
            REG_RANGE_MAXIMUM:  model_max  = value;
            REG_WRAP_MODE:      model_mode = value[0];
            REG_INCREMENT_STEP: model_inc  = value;
            REG_DECREMENT_STEP: model_dec  = value;
            REG_INITIAL_COUNT:  model_init = value;
            default:            ;
        endcase
    endtask

    // Registers are only touched with the block idle, so the whole set is
    // rewritten after the result channel has drained. The block never loads
    // the initial count, so writing it leaves the running count alone.
    task automatic configure(input logic signed [COUNT_WIDTH-1:0] lo,
                             input logic signed [COUNT_WIDTH-1:0] hi,
                             input logic mode,
                             input logic signed [COUNT_WIDTH-1:0] inc,
                             input logic signed [COUNT_WIDTH-1:0] dec,
                             input logic signed [COUNT_WIDTH-1:0] init);
        drain_results();
        apb_write(REG_RANGE_MINIMUM,  lo);
        apb_write(REG_RANGE_MAXIMUM,  hi);
        apb_write(REG_WRAP_MODE,      COUNT_WIDTH'(mode));
        apb_write(REG_INCREMENT_STEP, inc);
        apb_write(REG_DECREMENT_STEP, dec);
        apb_write(REG_INITIAL_COUNT,  init);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Most ranges are small so that wraps and clamps happen all the time;
    // the rest cover the full width, both edges of the number line, a single
    // point, and fully random limits, which come out inverted half the time.
    task automatic randomize_settings();
        longint lo;
        longint hi;
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
            begin
                lo = longint'($urandom_range(100)) - 50;
                hi = lo + longint'($urandom_range(30));
            end
            5:
            begin
                lo = longint'(MOST_NEG);
                hi = longint'(MOST_POS);
            end
            6:
            begin
                hi = longint'(MOST_POS);
                lo = hi - longint'($urandom_range(40));
            end
            7:
            begin
                lo = longint'(MOST_NEG);
                hi = lo + longint'($urandom_range(40));
            end
            8:
            begin
                lo = longint'($signed($urandom));
                hi = lo;
            end
            default:
            begin
                lo = longint'($signed($urandom));
                hi = longint'($signed($urandom));
            end
        endcase
        configure(COUNT_WIDTH'(lo), COUNT_WIDTH'(hi), logic'($urandom_range(1)),
                  pick_step(), pick_step(), $urandom);
    endtask

    // Random event. Set is kept to about a quarter of the events so that the
    // count mostly walks by steps; half of the set values land near the
    // range, the others are full random words.
    task automatic send_random_event();
        count_event_t ev;
        longint       lo;
        longint       hi;
        lo       = longint'($signed(model_min));
        hi       = longint'($signed(model_max));
        ev.inc   = logic'($urandom_range(1));
        ev.dec   = logic'($urandom_range(1));
        ev.set   = ($urandom_range(3) == 0);
        if ($urandom_range(1) == 1 && hi >= lo)
            ev.value = COUNT_WIDTH'(lo - 20 + rand_below(hi - lo + 41));
        else
            ev.value = $urandom;
        send_event(ev);
    endtask

    // Result side. Ready drops at random, except during the stretch in which
    // idling is switched off. Each result transfer is checked against the
    // oldest prediction; a transfer with nothing predicted is a failure too.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin : check_results
        count_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_counts.size() == 0)
            begin
                report_mismatch($sformatf("result with no event pending: count_out=%0d",
                                          result_ch.count_out));
            end
            else
            begin
                want = pending_counts.pop_front();
                if (result_ch.count_out !== want.count)
                    report_mismatch($sformatf("count_out=%0d, predicted %0d",
                                              result_ch.count_out, want.count));
                if (result_ch.range_error !== want.err)
                    report_mismatch($sformatf("range_error=%b, predicted %b",
                                              result_ch.range_error, want.err));
            end
        end
    end

    // Reset values: range 0..10, wrapping, unit steps, count at zero.
    // Crossing 10 upward must fold to 0 and crossing 0 downward to 10;
    // out-of-range set values in both directions go through the remainder.
    task automatic test_default_range();
        send_event(mk_event(1'b0, 1'b0, 1'b1, 10));
        send_event(mk_event(1'b1, 1'b0, 1'b0, 0));
        send_event(mk_event(1'b0, 1'b1, 1'b0, 0));
        send_event(mk_event(1'b1, 1'b1, 1'b0, 0));
        send_event(mk_event(1'b0, 1'b0, 1'b1, 25));
        send_event(mk_event(1'b0, 1'b0, 1'b1, -7));
        send_event(mk_event(1'b1, 1'b1, 1'b1, 3));
    endtask

    // Full 32-bit range with extreme steps: the exact sum leaves the count
    // width and the range size is 2**32. Subtracting the most negative step
    // is an addition of 2**31.
    task automatic test_full_range_wrap();
        configure(MOST_NEG, MOST_POS, MODE_WRAP, MOST_POS, MOST_NEG, 12345);
        send_event(mk_event(1'b0, 1'b0, 1'b1, MOST_POS));
        send_event(mk_event(1'b1, 1'b0, 1'b0, 0));
        send_event(mk_event(1'b0, 1'b1, 1'b0, 0));
        send_event(mk_event(1'b1, 1'b1, 1'b0, 0));
        send_event(mk_event(1'b0, 1'b0, 1'b1, MOST_NEG));
        send_event(mk_event(1'b0, 1'b1, 1'b0, 0));
    endtask

    // Same range in saturate mode: the count must stick at either limit.
    task automatic test_full_range_saturate();
        configure(MOST_NEG, MOST_POS, MODE_SATURATE, MOST_POS, MOST_POS, MOST_NEG);
        send_event(mk_event(1'b0, 1'b0, 1'b1, MOST_NEG));
        send_event(mk_event(1'b0, 1'b1, 1'b0, 0));
        send_event(mk_event(1'b1, 1'b0, 1'b0, 0));
        send_event(mk_event(1'b1, 1'b0, 1'b0, 0));
        send_event(mk_event(1'b0, 1'b1, 1'b0, 0));
    endtask

    // Maximum below minimum: the count is parked at the minimum with the
    // error flag, whatever the event asks. Then a one-value range in both
    // modes, and finally a normal range that must clamp the parked count
    // before stepping.
    task automatic test_inverted_and_single_point();
        configure(5, 4, MODE_WRAP, 1, 1, MOST_POS);
        send_event(mk_event(1'b1, 1'b0, 1'b0, 0));
        send_event(mk_event(1'b0, 1'b0, 1'b1, 0));
        configure(-3, -3, MODE_SATURATE, 1, 1, 0);
        send_event(mk_event(1'b1, 1'b0, 1'b0, 0));
        configure(-3, -3, MODE_WRAP, 1, 1, 0);
        send_event(mk_event(1'b0, 1'b1, 1'b0, 0));
        configure(0, 100, MODE_WRAP, 7, 3, 0);
        send_event(mk_event(1'b1, 1'b0, 1'b0, 0));
    endtask

    // Bulk of the random traffic: a fresh register set per phase.
    task automatic test_random_phases(input int phases, input int per_phase);
        repeat (phases)
        begin
            randomize_settings();
            repeat (per_phase)
                send_random_event();
        end
    endtask

    // Back-to-back traffic on both channels with idling switched off.
    task automatic test_no_idle_stretch(input int items);
        randomize_settings();
        no_idle = 1'b1;
        repeat (items)
            send_random_event();
        drain_results();
        no_idle = 1'b0;
    endtask

    // The sender stops every so often until all results are back, so the
    // block also sees events arriving into a completely empty pipeline.
    task automatic test_drain_between_bursts(input int bursts, input int burst_len);
        randomize_settings();
        repeat (bursts)
        begin
            repeat (burst_len)
                send_random_event();
            drain_results();
        end
    endtask

    initial
    begin
        error_count = 0;
        no_idle     = 1'b0;
        model_min   = RANGE_MINIMUM_RESET;
        model_max   = RANGE_MAXIMUM_RESET;
        model_mode  = WRAP_MODE_RESET;
        model_inc   = INCREMENT_STEP_RESET;
        model_dec   = DECREMENT_STEP_RESET;
        model_init  = INITIAL_COUNT_RESET;
        model_count = INITIAL_COUNT_RESET;

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        event_ch.valid        <= 1'b0;
        event_ch.do_increment <= 1'b0;
        event_ch.do_decrement <= 1'b0;
        event_ch.do_set       <= 1'b0;
        event_ch.set_value    <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_range();
        test_full_range_wrap();
        test_full_range_saturate();
        test_inverted_and_single_point();
        test_random_phases(30, 50);
        test_no_idle_stretch(200);
        test_drain_between_bursts(6, 25);

        // Everything is sent; let the last results arrive, then give the
        // block time to show any stray transfer before the verdict.
        drain_results();
        repeat (2 * EVENT_LATENCY)
            @(posedge clk);
        if (error_count == 0)
            $display("range_wrap_up_down_counter_tb: PASS");
        else
            $display("range_wrap_up_down_counter_tb: FAIL");
        $finish;
    end

endmodule
